// ----- design/vertex_position_dedup_defines.svh -----
// Assertion macros shared by the vertex position dedup RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef VERTEX_POSITION_DEDUP_DEFINES_SVH
`define VERTEX_POSITION_DEDUP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/vpd_pkg.sv -----
// Package for the vertex position dedup block: query type, constants and helpers.
// Used by vpd_cell, vpd_out_stage and vertex_position_dedup.
package vpd_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int COORD_W             = 32;
  localparam int INDEX_OUT_W         = 10;
  localparam int IN_DATA_W           = 96;
  localparam int OUT_DATA_W          = 112;
  localparam int OUT_USER_W          = 2;

  localparam logic [COORD_W-1:0] NEG_ZERO = 32'h8000_0000;

  // Bit positions of the result flags in out_tuser.
  localparam int USER_IS_NEW   = 0;
  localparam int USER_OVERFLOW = 1;

  // Position key with minus zero folded into plus zero.
  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } key_t;

  // One corner travelling down the chain of cells.
  typedef struct packed {
    logic       valid;
    key_t       key;
    logic [2:0] neg_zero;  // input coordinate was minus zero (z, y, x)
    logic       last;
    logic       found;
    logic       is_new;
  } query_t;

  function automatic logic [COORD_W-1:0] fold_zero(input logic [COORD_W-1:0] bits);
    fold_zero = (bits == NEG_ZERO) ? '0 : bits;
  endfunction

  function automatic logic [COORD_W-1:0] unfold_zero(input logic [COORD_W-1:0] bits,
                                                    input logic neg);
    unfold_zero = neg ? NEG_ZERO : bits;
  endfunction

endpackage

// ----- design/vpd_cell.sv -----
// One entry of the vertex table: a stored key, its valid bit and one query stage.
// Depends on vpd_pkg and vertex_position_dedup_defines.svh.
`include "vertex_position_dedup_defines.svh"

module vpd_cell #(
  parameter int TABLE_DEPTH = vpd_pkg::DEFAULT_TABLE_DEPTH,
  parameter int CELL_INDEX  = 0,
  localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv_i,
  input  vpd_pkg::query_t     q_i,
  input  logic [IDX_W-1:0]    idx_i,
  output vpd_pkg::query_t     q_o,
  output logic [IDX_W-1:0]    idx_o
);

  localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(CELL_INDEX);

  vpd_pkg::query_t   q_r, q_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  vpd_pkg::key_t     key_r, key_nxt;
  logic              hit;

  // Match or claim this entry, then drop it when the end of a mesh passes.
  always_comb begin
    q_nxt     = q_i;
    idx_nxt   = idx_i;
    valid_nxt = valid_r;
    key_nxt   = key_r;
    hit       = valid_r && (key_r == q_i.key);
    if (q_i.valid && !q_i.found && !q_i.is_new) begin
      if (hit) begin
        q_nxt.found = 1'b1;
        idx_nxt     = CELL_IDX;
      end else if (!valid_r) begin
        key_nxt      = q_i.key;
        valid_nxt    = 1'b1;
        q_nxt.is_new = 1'b1;
        idx_nxt      = CELL_IDX;
      end
    end
    if (q_i.valid && q_i.last) begin
      valid_nxt = 1'b0;
    end
  end

  // Control state of the cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      q_r     <= '0;
    end else if (adv_i) begin
      valid_r <= valid_nxt;
      q_r     <= q_nxt;
    end
  end

  // Stored key and index payload.
  always_ff @(posedge clk) begin
    if (adv_i) begin
      key_r <= key_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign q_o   = q_r;
  assign idx_o = idx_r;

  `VPD_ASSERT_NEXT(a_cell_clear, adv_i && q_i.valid && q_i.last, !valid_r,
                   "cell still valid after the end of a mesh passed")
  `VPD_ASSERT_NEXT(a_cell_claim,
                   adv_i && q_i.valid && !q_i.found && !q_i.is_new && !valid_r && !q_i.last,
                   valid_r && q_r.is_new && (idx_r == CELL_IDX),
                   "unseen position did not claim a free entry")

endmodule

// ----- design/vpd_out_stage.sv -----
// Output register of the vertex table: forms the result from the chain tail.
// Depends on vpd_pkg.
module vpd_out_stage #(
  parameter int TABLE_DEPTH = vpd_pkg::DEFAULT_TABLE_DEPTH,
  localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  vpd_pkg::query_t                 tail_q_i,
  input  logic [IDX_W-1:0]                tail_idx_i,
  output logic                            adv_o,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [vpd_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [vpd_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                            out_tlast
);

  logic                                     valid_r;
  logic [vpd_pkg::OUT_DATA_W-1:0]           data_r, data_nxt;
  logic [vpd_pkg::OUT_USER_W-1:0]           user_r, user_nxt;
  logic                                     last_r;
  logic [IDX_W+vpd_pkg::INDEX_OUT_W-1:0]    idx_ext;
  logic [vpd_pkg::INDEX_OUT_W-1:0]          idx_out;
  logic [vpd_pkg::COORD_W-1:0]              ex, ey, ez;
  logic                                     overflow;

  // The chain moves whenever the output register is free or being taken.
  assign adv_o = !valid_r || out_tready;

  // Result fields: index on hit or insert, echo only on insert.
  always_comb begin
    idx_ext  = {{vpd_pkg::INDEX_OUT_W{1'b0}}, tail_idx_i};
    overflow = !tail_q_i.found && !tail_q_i.is_new;
    idx_out  = overflow ? '0 : idx_ext[vpd_pkg::INDEX_OUT_W-1:0];
    ex = vpd_pkg::unfold_zero(tail_q_i.key.x, tail_q_i.neg_zero[0]);
    ey = vpd_pkg::unfold_zero(tail_q_i.key.y, tail_q_i.neg_zero[1]);
    ez = vpd_pkg::unfold_zero(tail_q_i.key.z, tail_q_i.neg_zero[2]);
    if (!tail_q_i.is_new) begin
      ex = '0;
      ey = '0;
      ez = '0;
    end
    data_nxt = {6'b0, ez, ey, ex, idx_out};
    user_nxt = '0;
    user_nxt[vpd_pkg::USER_IS_NEW]   = tail_q_i.is_new;
    user_nxt[vpd_pkg::USER_OVERFLOW] = overflow;
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv_o) begin
      valid_r <= tail_q_i.valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (adv_o) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
      last_r <= tail_q_i.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// ----- design/vertex_position_dedup.sv -----
// Vertex position dedup: exact-match welding of corner positions.
// The input stream carries one corner per transaction: in_tdata holds x, y and z
// as single-precision bit patterns, in_tlast marks the last corner of a mesh.
// Each corner travels down a chain of TABLE_DEPTH cells, one cell per cycle unless stalled.
// A cell that holds the same position (minus zero equal to plus zero) reports
// its index; the first free cell takes an unseen position and reports it as new.
// A corner that leaves the chain neither matched nor stored flags table overflow.
// The output stream returns one result transaction per corner, in order.
// A corner is registered in each cell of the chain in turn, then in the output register.
// Throughput is one corner per cycle while not stalled; corners overlap inside the chain.
// A corner marked last clears every cell right after passing it, so the next
// mesh starts empty without any clearing pass.
// Reset (rst_n low, synchronous) empties the chain and invalidates all cells.
// When the receiver holds out_tready low with a result waiting, the whole chain
// and in_tready stall until that result is taken.
// Depends on vpd_pkg, vpd_cell, vpd_out_stage and the defines header.
`include "vertex_position_dedup_defines.svh"

module vertex_position_dedup #(
  parameter int TABLE_DEPTH = vpd_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [vpd_pkg::IN_DATA_W-1:0]   in_tdata,   // pos_x, pos_y, pos_z
  input  logic                            in_tlast,   // mesh_end
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [vpd_pkg::OUT_DATA_W-1:0]  out_tdata,  // vertex_index, out_x, out_y, out_z
  output logic [vpd_pkg::OUT_USER_W-1:0]  out_tuser,  // is_new, table_overflow
  output logic                            out_tlast   // last_out
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  vpd_pkg::query_t   q_w   [TABLE_DEPTH+1];
  logic [IDX_W-1:0]  idx_w [TABLE_DEPTH+1];
  vpd_pkg::query_t   head_q;
  logic              adv;
  logic [vpd_pkg::COORD_W-1:0] px, py, pz;

  // Head of the chain: fold signed zeros and remember them for the echo.
  always_comb begin
    px = in_tdata[31:0];
    py = in_tdata[63:32];
    pz = in_tdata[95:64];
    head_q.valid       = in_tvalid;
    head_q.key.x       = vpd_pkg::fold_zero(px);
    head_q.key.y       = vpd_pkg::fold_zero(py);
    head_q.key.z       = vpd_pkg::fold_zero(pz);
    head_q.neg_zero[0] = (px == vpd_pkg::NEG_ZERO);
    head_q.neg_zero[1] = (py == vpd_pkg::NEG_ZERO);
    head_q.neg_zero[2] = (pz == vpd_pkg::NEG_ZERO);
    head_q.last        = in_tlast;
    head_q.found       = 1'b0;
    head_q.is_new      = 1'b0;
  end

  assign q_w[0]    = head_q;
  assign idx_w[0]  = '0;
  assign in_tready = adv;

  // Chain of table cells.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    vpd_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv_i (adv),
      .q_i   (q_w[i]),
      .idx_i (idx_w[i]),
      .q_o   (q_w[i+1]),
      .idx_o (idx_w[i+1])
    );
  end

  // Result register.
  vpd_out_stage #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail_q_i   (q_w[TABLE_DEPTH]),
    .tail_idx_i (idx_w[TABLE_DEPTH]),
    .adv_o      (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `VPD_ASSERT_SAME(a_tail_exclusive, q_w[TABLE_DEPTH].valid,
                   !(q_w[TABLE_DEPTH].found && q_w[TABLE_DEPTH].is_new),
                   "corner both matched and stored")
  `VPD_ASSERT_SAME(a_stall_cause, !in_tready, out_tvalid && !out_tready,
                   "input stalled without a waiting result")

endmodule

// ----- bench/corner_weld_checker.sv -----
// Scoreboard for vertex_position_dedup: watches both stream channels, predicts each result.
// Keeps its own copy of the welded position table. Depends on vpd_pkg.
module corner_weld_checker #(
  parameter int TABLE_DEPTH = vpd_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [vpd_pkg::IN_DATA_W-1:0]   in_tdata,   // pos_x, pos_y, pos_z
  input  logic                            in_tlast,   // mesh_end
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [vpd_pkg::OUT_DATA_W-1:0]  out_tdata,  // vertex_index, out_x, out_y, out_z
  input  logic [vpd_pkg::OUT_USER_W-1:0]  out_tuser,  // is_new, table_overflow
  input  logic                            out_tlast,  // last_out
  output int                              mismatches,
  output int                              pending
);

  typedef struct packed {
    logic [9:0]  index;
    logic        is_new;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        overflow;
    logic        last;
  } weld_result_t;

  // Results owed by the block, oldest first.
  weld_result_t due_results[$];

  // Unique positions of the current mesh, minus zero folded to plus zero.
  logic [95:0] welded_pos [TABLE_DEPTH];
  int          welded_count;
  int          fail_count;

  assign mismatches = fail_count;

  // Looks a corner up in the table, inserts it if unseen and room is left.
  function automatic weld_result_t weld_corner(input logic [95:0] raw, input logic last);
    logic [95:0]  key;
    logic [31:0]  coord;
    weld_result_t r;
    int           hit;
    int           i;
    for (int c = 0; c < 3; c++) begin
      coord = raw[32*c +: 32];
      key[32*c +: 32] = (coord == vpd_pkg::NEG_ZERO) ? 32'h0 : coord;
    end
    hit = -1;
    i = 0;
    while (hit < 0 && i < welded_count) begin
      if (welded_pos[i] == key) hit = i;
      i++;
    end
    r = '0;
    r.last = last;
    if (hit >= 0) begin
      r.index = hit[9:0];
    end else if (welded_count < TABLE_DEPTH) begin
      welded_pos[welded_count] = key;
      r.index = welded_count[9:0];
      r.is_new = 1'b1;
      r.x = raw[31:0];
      r.y = raw[63:32];
      r.z = raw[95:64];
      welded_count++;
    end else begin
      r.overflow = 1'b1;
    end
    // The end of a mesh empties the table after its own result.
    if (last) welded_count = 0;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    welded_count = 0;
    pending = 0;
  end

  // Predict on every input transaction, compare on every output transaction.
  always @(posedge clk) begin : watch
    weld_result_t want;
    if (!rst_n) begin
      due_results.delete();
      welded_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        due_results.insert(due_results.size(), weld_corner(in_tdata, in_tlast));
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: tdata %h, tuser %b, tlast %b",
                   $time, out_tdata, out_tuser, out_tlast);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          compare_field("vertex_index", 32'(want.index), 32'(out_tdata[9:0]));
          compare_field("out_x", want.x, out_tdata[41:10]);
          compare_field("out_y", want.y, out_tdata[73:42]);
          compare_field("out_z", want.z, out_tdata[105:74]);
          compare_field("tdata padding", 32'h0, 32'(out_tdata[111:106]));
          compare_field("is_new", 32'(want.is_new), 32'(out_tuser[vpd_pkg::USER_IS_NEW]));
          compare_field("table_overflow", 32'(want.overflow),
                        32'(out_tuser[vpd_pkg::USER_OVERFLOW]));
          compare_field("last_out", 32'(want.last), 32'(out_tlast));
        end
      end
    end
    pending = due_results.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the vertex_position_dedup bench: clock, reset, corner stimulus and verdict.
// Depends on vpd_pkg, the block itself and corner_weld_checker.
module testbench;

  localparam int          TABLE_DEPTH = vpd_pkg::DEFAULT_TABLE_DEPTH;
  localparam int          QUIET_LIMIT = 20000;
  localparam int          PHASE_LEN   = 120;
  localparam logic [31:0] NZ          = vpd_pkg::NEG_ZERO;
  localparam logic [31:0] ONES        = 32'hFFFF_FFFF;
  localparam logic [31:0] QNAN        = 32'h7FC0_0000;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [vpd_pkg::IN_DATA_W-1:0]   in_tdata   = '0;   // pos_x, pos_y, pos_z
  logic                            in_tlast   = 1'b0; // mesh_end
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [vpd_pkg::OUT_DATA_W-1:0]  out_tdata;         // vertex_index, out_x, out_y, out_z
  logic [vpd_pkg::OUT_USER_W-1:0]  out_tuser;         // is_new, table_overflow
  logic                            out_tlast;         // last_out

  int mismatches;
  int pending;
  int sent       = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int quiet      = 0;

  logic [95:0] filled_pos [TABLE_DEPTH];

  vertex_position_dedup #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  corner_weld_checker #(.TABLE_DEPTH(TABLE_DEPTH)) weld_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: too many cycles without any transaction ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Sends one corner; pos is {z, y, x}. Returns at the edge that accepts it.
  task automatic send_corner(input logic [95:0] pos, input logic last);
    // Idling phases rotate every PHASE_LEN transactions.
    case ((sent / PHASE_LEN) % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 80; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 80; end
      default: begin idle_pct = 16; stall_pct = 16; end
    endcase
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pos;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Coordinate biased toward the signed zeros, all ones and NaN.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: pick_coord = 32'h0;
      1: pick_coord = NZ;
      2: pick_coord = ONES;
      3: pick_coord = QNAN;
      default: pick_coord = $urandom;
    endcase
  endfunction

  // A short mesh drawn from a small pool of positions, so most corners repeat.
  task automatic run_mesh();
    logic [95:0] pool [16];
    logic [95:0] p;
    int          size;
    int          pool_n;
    size = $urandom_range(1, 40);
    pool_n = $urandom_range(1, 12);
    for (int k = 0; k < pool_n; k++) pool[k] = {pick_coord(), pick_coord(), pick_coord()};
    for (int k = 0; k < size; k++) begin
      if ($urandom_range(19) == 0) begin
        p = {pick_coord(), pick_coord(), pick_coord()};
      end else begin
        p = pool[$urandom_range(pool_n - 1)];
      end
      // Swap a zero coordinate for its other sign now and then.
      for (int c = 0; c < 3; c++) begin
        if ((p[32*c +: 32] == 32'h0 || p[32*c +: 32] == NZ) && $urandom_range(1))
          p[32*c +: 32] = p[32*c +: 32] ^ NZ;
      end
      send_corner(p, k == size - 1);
    end
  endtask

  // One long mesh that fills the table, then runs into overflow.
  task automatic fill_table();
    logic [95:0] p;
    int          n;
    n = 0;
    while (n < TABLE_DEPTH) begin
      if (n > 0 && $urandom_range(7) == 0) begin
        send_corner(filled_pos[$urandom_range(n - 1)], 1'b0);
      end else begin
        // Low bits of y carry the entry number, which keeps fresh positions distinct.
        p = {$urandom, $urandom, $urandom};
        p[42:32] = 11'(n);
        filled_pos[n] = p;
        send_corner(p, 1'b0);
        n++;
      end
    end
    // Table full: repeats still hit, unseen positions overflow.
    for (int k = 0; k < 48; k++) begin
      if ($urandom_range(1)) begin
        send_corner(filled_pos[$urandom_range(TABLE_DEPTH - 1)], 1'b0);
      end else begin
        p = {$urandom, $urandom, $urandom};
        p[42:32] = 11'(TABLE_DEPTH + k);
        send_corner(p, 1'b0);
      end
    end
    send_corner(filled_pos[TABLE_DEPTH - 1], 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: signed zeros, extremes, NaN and infinities, mesh ends.
    send_corner({32'h0, 32'h0, 32'h0}, 1'b0);
    send_corner({32'h0, 32'h0, NZ}, 1'b0);
    send_corner({NZ, NZ, 32'h0}, 1'b0);
    send_corner({ONES, ONES, ONES}, 1'b0);
    send_corner({32'hFF80_0000, 32'h7F80_0000, QNAN}, 1'b0);
    send_corner({32'hFF80_0000, 32'h7F80_0000, QNAN}, 1'b0);
    send_corner({NZ, NZ, NZ}, 1'b1);
    // After the mesh end the table is empty; minus zero is echoed as received.
    send_corner({NZ, NZ, NZ}, 1'b0);
    send_corner({32'h0, 32'h0, 32'h0}, 1'b0);
    send_corner({32'h0, 32'h0, 32'h1}, 1'b0);
    send_corner({32'h0, 32'h1, 32'h0}, 1'b0);
    send_corner({32'h1, 32'h0, 32'h0}, 1'b0);
    send_corner({NZ, 32'h0, ONES}, 1'b0);
    send_corner({32'h0, 32'h0, ONES}, 1'b1);
    // Single-corner meshes.
    send_corner({32'h0FED_CBA9, 32'h9ABC_DEF0, 32'h1234_5678}, 1'b1);
    send_corner({32'h0FED_CBA9, 32'h9ABC_DEF0, 32'h1234_5678}, 1'b1);
    // Patterns next to minus zero do not fold.
    send_corner({32'h0080_0000, 32'h7FFF_FFFF, 32'h8000_0001}, 1'b0);
    send_corner({32'h0080_0000, 32'h7FFF_FFFF, 32'h0000_0001}, 1'b1);

    while (sent < 650) run_mesh();
    fill_table();
    while (sent < 1900) run_mesh();
    in_tvalid <= 1'b0;

    // Drain, then give the cell chain time to show any stray result.
    while (pending != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- vertex_position_dedup.f -----
+incdir+design
design/vpd_pkg.sv
design/vpd_cell.sv
design/vpd_out_stage.sv
design/vertex_position_dedup.sv
bench/corner_weld_checker.sv
bench/testbench.sv
